FILE: src/per_slot_circuit_breaker_assert.svh
// Assertion macros used by the circuit breaker top level.
`ifndef PER_SLOT_CIRCUIT_BREAKER_ASSERT_SVH
`define PER_SLOT_CIRCUIT_BREAKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge outside reset.
`define PSC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("circuit breaker assertion failed");

// Property checked on every rising edge, reset included.
`define PSC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("circuit breaker assertion failed");

`else

`define PSC_ASSERT(label, clk, rstn, prop)
`define PSC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: src/psc_pkg.sv
// Package with types and constants for the per-slot circuit breaker.
`timescale 1ns / 1ps

package psc_pkg;

    // Slot table geometry.
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = 4;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_EXT_W = (SLOT_IDX_W > SLOT_W) ? SLOT_IDX_W : SLOT_W;

    // Field widths.
    localparam int ACTION_W    = 2;
    localparam int MODE_W      = 2;
    localparam int RUN_W       = 8;
    localparam int CNT_W       = 32;
    localparam int TIME_W      = 32;
    localparam int THRESH_W    = 8;
    localparam int TIMEOUT_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FAILURE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIMEOUT      = 1'd1;
    localparam logic [THRESH_W-1:0]  THRESHOLD_RESET       = 8'd5;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET         = 16'd30;

    // Stream payload widths.
    localparam int S_FIELDS_W = ACTION_W + SLOT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + MODE_W + RUN_W + CNT_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Saturation limits.
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_FAILURE = 2'd2,
        ACT_SUCCESS = 2'd3
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_HALF   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EXEC = 2'd2,
        ST_OUT  = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic exec;
    } cmd_t;

endpackage

FILE: src/psc_ctrl.sv
// Controller state machine that sequences one beat through the datapath.
`timescale 1ns / 1ps

module psc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output psc_pkg::cmd_t  cmd
);
    import psc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: accept, read the slot, update it, then present the result.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the current state.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ: begin
                cmd.read = 1'b1;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/psc_dp.sv
// Datapath: slot table, tick counter, configuration and result register.
`timescale 1ns / 1ps

module psc_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [psc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  psc_pkg::cmd_t                    cmd,
    input  logic                             cfg_wr_en,
    input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [psc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import psc_pkg::*;

    // Configuration and time.
    logic [THRESH_W-1:0]  threshold_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIME_W-1:0]    seconds_reg;

    // Captured input beat.
    action_t              action_reg;
    logic [SLOT_W-1:0]    slot_reg;

    // Slot table.
    mode_t                mode_tab_reg   [NUM_SLOTS];
    logic [TIME_W-1:0]    reopen_tab_reg [NUM_SLOTS];
    logic [RUN_W-1:0]     run_tab_reg    [NUM_SLOTS];
    logic [CNT_W-1:0]     sent_tab_reg   [NUM_SLOTS];
    logic [CNT_W-1:0]     failed_tab_reg [NUM_SLOTS];

    // Entry read for the current beat.
    mode_t                rd_mode_reg;
    logic [TIME_W-1:0]    rd_reopen_reg;
    logic [RUN_W-1:0]     rd_run_reg;
    logic [CNT_W-1:0]     rd_sent_reg;
    logic [CNT_W-1:0]     rd_failed_reg;

    // Result register.
    logic                 out_allow_reg;
    logic [MODE_W-1:0]    out_mode_reg;
    logic [RUN_W-1:0]     out_run_reg;
    logic [CNT_W-1:0]     out_sent_reg;
    logic [CNT_W-1:0]     out_failed_reg;

    // Updated entry.
    logic                 allow_next;
    mode_t                mode_next;
    logic [TIME_W-1:0]    reopen_next;
    logic [RUN_W-1:0]     run_next;
    logic [CNT_W-1:0]     sent_next;
    logic [CNT_W-1:0]     failed_next;

    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic                  slot_ok;
    logic                  entry_hit;
    logic [TIME_W-1:0]     time_diff;
    logic                  reopen_due;
    logic [TIME_W-1:0]     reopen_calc;
    logic [RUN_W-1:0]      run_inc;
    logic [CNT_W-1:0]      sent_inc;
    logic [CNT_W-1:0]      failed_inc;

    // Slot decode; slots at or above the table size are left alone.
    assign slot_ext  = SLOT_EXT_W'(slot_reg);
    assign slot_idx  = slot_ext[SLOT_IDX_W-1:0];
    assign slot_ok   = (32'(slot_reg) < NUM_SLOTS);
    assign entry_hit = slot_ok && (action_reg != ACT_TICK);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            timeout_reg   <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx)
                REG_FAILURE_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_W-1:0];
                REG_OPEN_TIMEOUT:      timeout_reg   <= cfg_wdata[TIMEOUT_W-1:0];
                default:               threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Input beat capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= action_t'(s_tdata[ACTION_W-1:0]);
            slot_reg   <= s_tdata[ACTION_W +: SLOT_W];
        end
    end

    // Tick counter wraps freely.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_reg <= '0;
        end else if (cmd.exec && (action_reg == ACT_TICK)) begin
            seconds_reg <= seconds_reg + TIME_W'(1);
        end
    end

    // Registered read of the addressed entry.
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_mode_reg   <= mode_tab_reg[slot_idx];
            rd_reopen_reg <= reopen_tab_reg[slot_idx];
            rd_run_reg    <= run_tab_reg[slot_idx];
            rd_sent_reg   <= sent_tab_reg[slot_idx];
            rd_failed_reg <= failed_tab_reg[slot_idx];
        end
    end

    // Saturating increments, wrap-safe reopen check and new reopen time.
    assign time_diff   = seconds_reg - rd_reopen_reg;
    assign reopen_due  = !time_diff[TIME_W-1];
    assign reopen_calc = seconds_reg + TIME_W'(timeout_reg);
    assign run_inc     = (rd_run_reg == RUN_MAX) ? RUN_MAX : rd_run_reg + RUN_W'(1);
    assign sent_inc    = (rd_sent_reg == CNT_MAX) ? CNT_MAX : rd_sent_reg + CNT_W'(1);
    assign failed_inc  = (rd_failed_reg == CNT_MAX) ? CNT_MAX : rd_failed_reg + CNT_W'(1);

    // Breaker update for the addressed slot.
    always_comb begin
        allow_next  = 1'b0;
        mode_next   = rd_mode_reg;
        reopen_next = rd_reopen_reg;
        run_next    = rd_run_reg;
        sent_next   = rd_sent_reg;
        failed_next = rd_failed_reg;
        case (action_reg)
            ACT_QUERY: begin
                if (rd_mode_reg == MODE_OPEN) begin
                    if (reopen_due) begin
                        mode_next  = MODE_HALF;
                        allow_next = 1'b1;
                    end
                end else begin
                    allow_next = 1'b1;
                end
            end
            ACT_FAILURE: begin
                run_next    = run_inc;
                failed_next = failed_inc;
                if (run_inc >= threshold_reg) begin
                    mode_next   = MODE_OPEN;
                    reopen_next = reopen_calc;
                end
            end
            ACT_SUCCESS: begin
                run_next  = '0;
                sent_next = sent_inc;
                if (rd_mode_reg == MODE_HALF) begin
                    mode_next = MODE_CLOSED;
                end
            end
            default: begin
                allow_next = 1'b0;
            end
        endcase
    end

    // Slot table write-back; reset closes every breaker and clears counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                mode_tab_reg[i]   <= MODE_CLOSED;
                reopen_tab_reg[i] <= '0;
                run_tab_reg[i]    <= '0;
                sent_tab_reg[i]   <= '0;
                failed_tab_reg[i] <= '0;
            end
        end else if (cmd.exec && entry_hit) begin
            mode_tab_reg[slot_idx]   <= mode_next;
            reopen_tab_reg[slot_idx] <= reopen_next;
            run_tab_reg[slot_idx]    <= run_next;
            sent_tab_reg[slot_idx]   <= sent_next;
            failed_tab_reg[slot_idx] <= failed_next;
        end
    end

    // Result register; ticks and unknown slots report all zeros.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (entry_hit) begin
                out_allow_reg  <= allow_next;
                out_mode_reg   <= mode_next;
                out_run_reg    <= run_next;
                out_sent_reg   <= sent_next;
                out_failed_reg <= failed_next;
            end else begin
                out_allow_reg  <= 1'b0;
                out_mode_reg   <= '0;
                out_run_reg    <= '0;
                out_sent_reg   <= '0;
                out_failed_reg <= '0;
            end
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, out_failed_reg, out_sent_reg, out_run_reg,
                      out_mode_reg, out_allow_reg};

endmodule

FILE: src/per_slot_circuit_breaker.sv
// Top level of the per-slot circuit breaker.
`timescale 1ns / 1ps
`include "per_slot_circuit_breaker_assert.svh"

// Keeps a closed/open/half-open breaker, a saturating failure run and
// saturating sent and failed totals for each of 16 backend slots, plus a
// tick counter that serves as the time base. Every input beat (tick, query,
// failure report or success report) yields exactly one result beat. An item
// passes in order through accept, read of the slot entry, update and
// write-back, and the result beat; the block works on one item at a time and
// holds the next until the result has left. A stalled result holds the block
// in the result beat until it is taken. Configuration writes take effect on
// the next edge and are meant for when the block is idle.
module per_slot_circuit_breaker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata fields from bit 0: action[1:0], slot[5:2], zero padding.
    input  logic [psc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata fields from bit 0: allow[0], breaker_mode[2:1],
    // failure_run[10:3], sent_total[42:11], failed_total[74:43], zero padding.
    output logic [psc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import psc_pkg::*;

    cmd_t cmd;

    // Sequencer.
    psc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Slot table and result path.
    psc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

    // The two sides never hand over a beat at the same time.
    `PSC_ASSERT(a_one_side, aclk, aresetn, !(s_tready && m_tvalid))
    // A result beat follows an input beat after the read and update states.
    `PSC_ASSERT(a_latency, aclk, aresetn, (s_tvalid && s_tready) |=> (!m_tvalid ##1 !m_tvalid ##1 m_tvalid))
    // A permitted send never reports the slot as open.
    `PSC_ASSERT(a_allow_mode, aclk, aresetn, (m_tvalid && m_tdata[0]) |-> (m_tdata[2:1] != MODE_OPEN))
    // The reported mode is always a defined breaker mode.
    `PSC_ASSERT(a_mode_legal, aclk, aresetn, m_tvalid |-> !(m_tdata[1] && m_tdata[2]))

endmodule
